// ===== design/kmp_pkg.sv =====
// Shared types, codes and default sizes for the KMP substring search core.
package kmp_pkg;

    localparam int MAX_PATTERN_DEF   = 64;
    localparam int POSITION_BITS_DEF = 32;
    localparam int START_W           = 16;
    localparam int MATCH_POS_W       = 32;

    localparam logic [START_W-1:0] START_RESET = 16'd1;

    typedef enum logic [1:0] {
        CMD_PATTERN = 2'd0,
        CMD_TEXT    = 2'd1,
        CMD_CLEAR   = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        ST_PENDING   = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_DROPPED   = 2'd3
    } status_t;

    typedef struct packed {
        command_t   command;
        logic [7:0] data_byte;
        logic       last_byte;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic [MATCH_POS_W-1:0] match_position;
    } rsp_t;

endpackage

// ===== design/kmp_substring_search_core.sv =====
// Top level of the KMP substring search core: sequencer, state and result register.
//
// Each request gives exactly one response. A clear, an unused command, a dropped pattern
// byte, a text byte outside the active search or while the pattern is empty, and one of
// the first two pattern bytes go from idle straight to S_RESULT. A later pattern byte
// passes through S_LD_PREV and, if needed, walks the failure links in S_LD_WALK while its
// failure entry is built, and a searched text byte walks the failure links in S_TX_WALK,
// one compare step at a time. Every step is one read of the pattern and failure memories,
// whose single registered read port paces the walk; over a text the failure links
// followed average at most one per byte. S_RESULT waits while the response register
// still holds a response that is not taken, then loads the response as the core returns
// to idle. The response register lets the core accept the next request while a response
// still waits to be taken.
module kmp_substring_search_core #(
    parameter int MAX_PATTERN   = kmp_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  kmp_pkg::req_t                s_req,
    output logic                         m_valid,
    input  logic                         m_ready,
    output kmp_pkg::rsp_t                m_rsp,
    input  logic                         cfg_we,
    input  logic [kmp_pkg::START_W-1:0]  cfg_wdata
);

    localparam int IDX_W  = $clog2(MAX_PATTERN);
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W  = (POSITION_BITS > kmp_pkg::START_W) ? POSITION_BITS
                                                               : kmp_pkg::START_W;
    localparam int CALC_W = (POSITION_BITS > kmp_pkg::MATCH_POS_W) ? POSITION_BITS
                                                                   : kmp_pkg::MATCH_POS_W;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_LD_PREV = 5'b00010,
        S_LD_WALK = 5'b00100,
        S_TX_WALK = 5'b01000,
        S_RESULT  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    kmp_pkg::req_t                   req_reg, req_next;
    kmp_pkg::rsp_t                   res_reg, res_next;
    kmp_pkg::rsp_t                   m_rsp_reg, m_rsp_next;
    logic                            m_valid_reg, m_valid_next;
    logic [LEN_W-1:0]                len_reg, len_next;
    logic [LEN_W-1:0]                matched_reg, matched_next;
    logic [LEN_W-1:0]                j_reg, j_next;
    logic [POSITION_BITS-1:0]        tp_reg, tp_next;
    logic                            done_reg, done_next;
    logic [7:0]                      prev_reg, prev_next;
    logic [kmp_pkg::START_W-1:0]     start_reg;

    logic                            store_we;
    logic [IDX_W-1:0]                store_waddr;
    logic [7:0]                      store_rd;
    logic                            fail_we;
    logic [IDX_W-1:0]                fail_waddr;
    logic [IDX_W-1:0]                fail_wdata;
    logic [IDX_W-1:0]                fail_rd;
    logic [IDX_W-1:0]                rd_addr;

    logic [POSITION_BITS-1:0]        tp_inc;
    logic [kmp_pkg::START_W-1:0]     start_eff;
    logic                            active;
    logic [LEN_W-1:0]                k_val;
    logic [LEN_W-1:0]                j_new;
    logic                            ld_fin;
    logic [LEN_W-1:0]                ld_val;
    logic                            tx_fin;
    logic [CALC_W-1:0]               mpos_calc;

    kmp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PATTERN)
    ) u_pattern_ram (
        .aclk    (aclk),
        .wr_en   (store_we),
        .wr_addr (store_waddr),
        .wr_data (req_next.data_byte),
        .rd_addr (rd_addr),
        .rd_data (store_rd)
    );

    kmp_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_PATTERN)
    ) u_failure_ram (
        .aclk    (aclk),
        .wr_en   (fail_we),
        .wr_addr (fail_waddr),
        .wr_data (fail_wdata),
        .rd_addr (rd_addr),
        .rd_data (fail_rd)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_rsp     = m_rsp_reg;
    assign tp_inc    = (tp_reg == {POSITION_BITS{1'b1}}) ? tp_reg
                                                         : tp_reg + POSITION_BITS'(1);
    assign start_eff = (start_reg == '0) ? kmp_pkg::START_W'(1) : start_reg;
    assign active    = !done_reg && (CMP_W'(tp_inc) >= CMP_W'(start_eff));
    assign k_val     = LEN_W'(fail_rd);
    assign mpos_calc = CALC_W'(tp_reg) - CALC_W'(len_reg) + CALC_W'(1);

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        len_next     = len_reg;
        matched_next = matched_reg;
        j_next       = j_reg;
        tp_next      = tp_reg;
        done_next    = done_reg;
        prev_next    = prev_reg;
        store_we     = 1'b0;
        store_waddr  = len_reg[IDX_W-1:0];
        fail_we      = 1'b0;
        fail_waddr   = len_reg[IDX_W-1:0];
        fail_wdata   = '0;
        rd_addr      = j_reg[IDX_W-1:0];
        j_new        = j_reg;
        ld_fin       = 1'b0;
        ld_val       = '0;
        tx_fin       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_req;
                    state_next = S_RESULT;
                    res_next   = '{status: kmp_pkg::ST_PENDING, match_position: '0};
                    case (s_req.command)
                        kmp_pkg::CMD_CLEAR: begin
                            len_next     = '0;
                            tp_next      = '0;
                            matched_next = '0;
                            done_next    = 1'b0;
                        end
                        kmp_pkg::CMD_PATTERN: begin
                            if (len_reg >= LEN_W'(MAX_PATTERN)) begin
                                res_next.status = kmp_pkg::ST_DROPPED;
                            end else begin
                                store_we = 1'b1;
                                if (len_reg < LEN_W'(2)) begin
                                    fail_we  = 1'b1;
                                    len_next = len_reg + LEN_W'(1);
                                end else begin
                                    j_next     = len_reg - LEN_W'(1);
                                    rd_addr    = j_next[IDX_W-1:0];
                                    state_next = S_LD_PREV;
                                end
                            end
                        end
                        kmp_pkg::CMD_TEXT: begin
                            tp_next = tp_inc;
                            if (!active) begin
                                if (s_req.last_byte && !done_reg) begin
                                    res_next.status = kmp_pkg::ST_NOT_FOUND;
                                end
                                if (s_req.last_byte) begin
                                    tp_next      = '0;
                                    matched_next = '0;
                                    done_next    = 1'b0;
                                end
                            end else if (len_reg == '0) begin
                                res_next.status         = kmp_pkg::ST_FOUND;
                                res_next.match_position =
                                    kmp_pkg::MATCH_POS_W'(CALC_W'(tp_inc));
                                done_next = 1'b1;
                                if (s_req.last_byte) begin
                                    tp_next      = '0;
                                    matched_next = '0;
                                    done_next    = 1'b0;
                                end
                            end else begin
                                j_next     = matched_reg;
                                rd_addr    = matched_reg[IDX_W-1:0];
                                state_next = S_TX_WALK;
                            end
                        end
                        default: begin
                            res_next.status = kmp_pkg::ST_PENDING;
                        end
                    endcase
                end
            end

            S_LD_PREV: begin
                prev_next = store_rd;
                if (k_val >= j_reg) begin
                    ld_fin = 1'b1;
                end else begin
                    j_next     = k_val;
                    rd_addr    = k_val[IDX_W-1:0];
                    state_next = S_LD_WALK;
                end
            end

            S_LD_WALK: begin
                if (store_rd == prev_reg) begin
                    ld_fin = 1'b1;
                    ld_val = j_reg + LEN_W'(1);
                end else if (j_reg == '0 || k_val >= j_reg) begin
                    ld_fin = 1'b1;
                end else begin
                    j_next  = k_val;
                    rd_addr = k_val[IDX_W-1:0];
                end
            end

            S_TX_WALK: begin
                if (j_reg < len_reg && store_rd == req_reg.data_byte) begin
                    j_new  = j_reg + LEN_W'(1);
                    tx_fin = 1'b1;
                end else if (j_reg == '0 || j_reg >= LEN_W'(MAX_PATTERN)) begin
                    tx_fin = 1'b1;
                end else begin
                    j_new   = (k_val < j_reg) ? k_val : '0;
                    j_next  = j_new;
                    rd_addr = j_new[IDX_W-1:0];
                end
            end

            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (ld_fin) begin
            fail_we    = 1'b1;
            fail_wdata = ld_val[IDX_W-1:0];
            len_next   = len_reg + LEN_W'(1);
            state_next = S_RESULT;
        end

        if (tx_fin) begin
            state_next = S_RESULT;
            if (j_new >= len_reg) begin
                res_next.status         = kmp_pkg::ST_FOUND;
                res_next.match_position = mpos_calc[kmp_pkg::MATCH_POS_W-1:0];
                matched_next            = '0;
                done_next               = 1'b1;
            end else begin
                matched_next = j_new;
                if (req_reg.last_byte) begin
                    res_next.status = kmp_pkg::ST_NOT_FOUND;
                end
            end
            if (req_reg.last_byte) begin
                tp_next      = '0;
                matched_next = '0;
                done_next    = 1'b0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_rsp_next   = m_rsp_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == S_RESULT && (!m_valid_reg || m_ready)) begin
            m_valid_next = 1'b1;
            m_rsp_next   = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            len_reg     <= '0;
            matched_reg <= '0;
            tp_reg      <= '0;
            done_reg    <= 1'b0;
            start_reg   <= kmp_pkg::START_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            len_reg     <= len_next;
            matched_reg <= matched_next;
            tp_reg      <= tp_next;
            done_reg    <= done_next;
            if (cfg_we) begin
                start_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        res_reg   <= res_next;
        m_rsp_reg <= m_rsp_next;
        j_reg     <= j_next;
        prev_reg  <= prev_next;
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(MAX_PATTERN))
        else $error("Pattern length exceeds capacity.");

    a_matched_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg == '0 && matched_reg == '0) || (matched_reg < len_reg))
        else $error("Partial match is not shorter than the pattern.");

    a_drop_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT && res_reg.status == kmp_pkg::ST_DROPPED)
        |-> (len_reg == LEN_W'(MAX_PATTERN)))
        else $error("Pattern byte dropped while the pattern store has room.");

    a_found_sets_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT && res_reg.status == kmp_pkg::ST_FOUND)
        |-> (done_reg || req_reg.last_byte))
        else $error("Match reported without closing the search.");
`endif

endmodule

// ===== design/kmp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== test/kmp_substring_search_core_test.sv =====
// Testbench for the KMP substring search core: directed and random requests checked in order.
module kmp_substring_search_core_test;

    localparam int          MAXP         = kmp_pkg::MAX_PATTERN_DEF;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [31:0] POS_MAX      = '1;
    localparam int          LIMIT_CYCLES = 3_000_000;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         s_valid   = 1'b0;
    logic                         s_ready;
    kmp_pkg::req_t                s_req     = '0;
    logic                         m_valid;
    logic                         m_ready   = 1'b0;
    kmp_pkg::rsp_t                m_rsp;
    logic                         cfg_we    = 1'b0;
    logic [kmp_pkg::START_W-1:0]  cfg_wdata = '0;

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int rx_hold_left = 0;
    int fail_count   = 0;
    int cycle_count  = 0;
    int sent_items   = 0;

    kmp_pkg::rsp_t owed_results [$];

    // Mirror of the search state.
    logic [7:0]   pat_bytes  [0:MAXP-1];
    int           border_len [0:MAXP-1];
    int           pat_len    = 0;
    int           match_len  = 0;
    logic [31:0]  text_pos   = '0;
    bit           search_hit = 1'b0;
    logic [15:0]  start_pos  = kmp_pkg::START_RESET;

    kmp_substring_search_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rsp     (m_rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (rx_hold_left != 0) begin
            m_ready      <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        kmp_pkg::rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                fail_count++;
                $error("result arrived with no request outstanding");
            end else begin
                want = owed_results.pop_front();
                if (m_rsp.status !== want.status) begin
                    fail_count++;
                    $error("status: expected %0d, actual %0d", want.status, m_rsp.status);
                end
                if (m_rsp.match_position !== want.match_position) begin
                    fail_count++;
                    $error("match_position: expected %0d, actual %0d",
                           want.match_position, m_rsp.match_position);
                end
            end
        end
    end

    function automatic kmp_pkg::rsp_t search_step(kmp_pkg::req_t r);
        kmp_pkg::rsp_t res;
        int            n;
        int            j;
        int            k;
        int            f;
        bit            walking;
        bit            hit;
        logic [31:0]   first;
        res.status         = kmp_pkg::ST_PENDING;
        res.match_position = '0;
        hit                = 1'b0;
        case (r.command)
            kmp_pkg::CMD_CLEAR: begin
                pat_len    = 0;
                match_len  = 0;
                text_pos   = '0;
                search_hit = 1'b0;
            end
            kmp_pkg::CMD_PATTERN: begin
                n = pat_len;
                if (n >= MAXP) begin
                    res.status = kmp_pkg::ST_DROPPED;
                end else begin
                    pat_bytes[n] = r.data_byte;
                    f = 0;
                    if (n >= 2) begin
                        j       = n - 1;
                        walking = 1'b1;
                        while (walking && j != 0) begin
                            k = border_len[j];
                            if (k >= j) begin
                                walking = 1'b0;
                            end else if (pat_bytes[k] == pat_bytes[n-1]) begin
                                f       = k + 1;
                                walking = 1'b0;
                            end else begin
                                j = k;
                            end
                        end
                    end
                    border_len[n] = f;
                    pat_len       = n + 1;
                end
            end
            kmp_pkg::CMD_TEXT: begin
                first = (start_pos == 16'd0) ? 32'd1 : {16'd0, start_pos};
                if (text_pos != POS_MAX)
                    text_pos = text_pos + 1;
                if (!search_hit && text_pos >= first) begin
                    if (pat_len == 0) begin
                        hit                = 1'b1;
                        res.match_position = text_pos;
                    end else begin
                        j       = match_len;
                        walking = 1'b1;
                        while (walking) begin
                            if (j < pat_len && pat_bytes[j] == r.data_byte) begin
                                j++;
                                walking = 1'b0;
                            end else if (j == 0 || j >= MAXP) begin
                                walking = 1'b0;
                            end else begin
                                j = (border_len[j] < j) ? border_len[j] : 0;
                            end
                        end
                        if (j >= pat_len) begin
                            hit                = 1'b1;
                            res.match_position = text_pos - pat_len + 1;
                            match_len          = 0;
                        end else begin
                            match_len = j;
                        end
                    end
                end
                if (hit) begin
                    res.status = kmp_pkg::ST_FOUND;
                    search_hit = 1'b1;
                end else if (r.last_byte && !search_hit) begin
                    res.status = kmp_pkg::ST_NOT_FOUND;
                end
                if (r.last_byte) begin
                    text_pos   = '0;
                    match_len  = 0;
                    search_hit = 1'b0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] data, input bit last);
        kmp_pkg::req_t r;
        r.command   = kmp_pkg::command_t'(cmd);
        r.data_byte = data;
        r.last_byte = last;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        owed_results.push_back(search_step(r));
        if (cmd != CMD_UNUSED)
            sent_items++;
    endtask

    task automatic send_pattern(input string s);
        for (int i = 0; i < s.len(); i++)
            send_cmd(kmp_pkg::CMD_PATTERN, s[i], 1'b0);
    endtask

    task automatic send_text(input string s, input bit ends);
        for (int i = 0; i < s.len(); i++)
            send_cmd(kmp_pkg::CMD_TEXT, s[i], ends && (i == s.len() - 1));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_start(input logic [15:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        start_pos  = value;
    endtask

    task automatic test_empty_pattern();
        send_text("abc", 1'b1);
        write_start(16'd0);
        send_text("xy", 1'b1);
        write_start(16'd3);
        send_text("pqrst", 1'b1);
        send_text("pq", 1'b1);
    endtask

    task automatic test_basic_search();
        write_start(16'd1);
        send_cmd(kmp_pkg::CMD_CLEAR, 8'hFF, 1'b1);
        send_pattern("aba");
        send_text("xxababa", 1'b1);
        send_text("bbb", 1'b1);
        write_start(16'd2);
        send_text("ababa", 1'b1);
        write_start(16'd1);
        send_cmd(kmp_pkg::CMD_CLEAR, 8'h00, 1'b0);
        send_cmd(kmp_pkg::CMD_PATTERN, 8'h00, 1'b1);
        send_cmd(kmp_pkg::CMD_PATTERN, 8'hFF, 1'b0);
        send_cmd(kmp_pkg::CMD_TEXT, 8'hFF, 1'b0);
        send_cmd(kmp_pkg::CMD_TEXT, 8'h00, 1'b0);
        send_cmd(kmp_pkg::CMD_TEXT, 8'hFF, 1'b1);
    endtask

    task automatic test_pattern_during_text();
        send_cmd(kmp_pkg::CMD_CLEAR, 8'h00, 1'b0);
        send_pattern("ab");
        send_text("a", 1'b0);
        send_pattern("c");
        send_text("bc", 1'b1);
    endtask

    task automatic test_full_pattern();
        send_cmd(kmp_pkg::CMD_CLEAR, 8'h00, 1'b0);
        for (int i = 0; i < MAXP - 1; i++)
            send_cmd(kmp_pkg::CMD_PATTERN, "a", 1'b0);
        send_cmd(kmp_pkg::CMD_PATTERN, "b", 1'b0);
        send_cmd(kmp_pkg::CMD_PATTERN, 8'h5A, 1'b0);
        send_cmd(kmp_pkg::CMD_PATTERN, 8'hA5, 1'b1);
        for (int i = 0; i < MAXP; i++)
            send_cmd(kmp_pkg::CMD_TEXT, "a", 1'b0);
        send_cmd(kmp_pkg::CMD_TEXT, "b", 1'b1);
    endtask

    task automatic test_unused_command();
        send_cmd(CMD_UNUSED, 8'hFF, 1'b1);
        send_cmd(CMD_UNUSED, 8'h00, 1'b0);
        send_text("ab", 1'b1);
    endtask

    task automatic test_far_start();
        write_start(16'hFFFF);
        send_cmd(kmp_pkg::CMD_CLEAR, 8'h00, 1'b0);
        send_text("abc", 1'b1);
        for (int i = 0; i < 20; i++)
            send_cmd(kmp_pkg::CMD_TEXT, 8'($urandom_range(255)), 1'b0);
        send_cmd(kmp_pkg::CMD_TEXT, 8'($urandom_range(255)), 1'b1);
        write_start(16'd1);
    endtask

    task automatic test_backpressure();
        write_start(16'd1);
        send_cmd(kmp_pkg::CMD_CLEAR, 8'h00, 1'b0);
        send_pattern("abc");
        rx_hold_left <= 400;
        for (int i = 0; i < 40; i++)
            send_cmd(kmp_pkg::CMD_TEXT, 8'("a" + $urandom_range(2)), i == 39);
        wait_idle();
    endtask

    task automatic test_random(input int tx_pct, input int rx_pct, input int count);
        logic [7:0] syms [0:2];
        logic [7:0] pat  [0:127];
        logic [7:0] txt  [0:127];
        int         goal;
        int         plen;
        int         tlen;
        int         off;
        int         pick;
        bit         ends;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        pick = $urandom_range(3);
        write_start(pick == 0 ? 16'd0 : pick == 1 ? 16'd1 : 16'($urandom_range(2, 10)));
        goal = sent_items + count;
        while (sent_items < goal) begin
            for (int i = 0; i < 3; i++)
                syms[i] = 8'($urandom_range(255));
            if ($urandom_range(99) < 80)
                send_cmd(kmp_pkg::CMD_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
            pick = $urandom_range(99);
            if (pick < 15)
                plen = 0;
            else if (pick < 85)
                plen = $urandom_range(1, 6);
            else if (pick < 95)
                plen = $urandom_range(7, 20);
            else
                plen = $urandom_range(60, 68);
            for (int i = 0; i < plen; i++) begin
                pat[i] = syms[$urandom_range(2)];
                send_cmd(kmp_pkg::CMD_PATTERN, pat[i], 1'($urandom_range(1)));
            end
            tlen = $urandom_range(1, 24);
            for (int i = 0; i < tlen; i++)
                txt[i] = syms[$urandom_range(2)];
            if (plen > 0 && plen <= tlen && $urandom_range(99) < 60) begin
                off = $urandom_range(tlen - plen);
                for (int i = 0; i < plen; i++)
                    txt[off + i] = pat[i];
            end
            ends = ($urandom_range(99) < 90);
            for (int i = 0; i < tlen; i++) begin
                if ($urandom_range(99) < 4)
                    send_cmd($urandom_range(1) ? CMD_UNUSED : 2'(kmp_pkg::CMD_PATTERN),
                             8'($urandom_range(255)), 1'($urandom_range(1)));
                send_cmd(kmp_pkg::CMD_TEXT, txt[i], ends && (i == tlen - 1));
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 37;
        rx_idle_pct = 84;
        test_empty_pattern();
        test_basic_search();
        test_pattern_during_text();
        test_full_pattern();
        test_unused_command();
        test_random(37, 84, 55);
        test_random(84, 37, 55);
        test_random(0, 0, 55);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_far_start();
        test_backpressure();

        wait_idle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
